FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Every module that uses them names its
// clock "clock" and its synchronous reset "reset".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   `ASSERT_ALWAYS(lbl, !(cond), msg)

`endif

FILE: hdl/rslp_pkg.sv
package rslp_pkg;

   // Configuration storage layout.
   localparam int COUNT_BITS     = 4;
   localparam int ANGLE_BITS     = 15;
   localparam int CHAN_BITS      = 3;
   localparam int SLOTS_PER_WORD = 4;
   localparam int CSR_DATA_BITS  = 60;
   localparam int CSR_INDEX_BITS = 2;
   localparam int MAP_BITS       = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEAKER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLES_LO     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLES_HI     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_MAP   = 2'd3;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 4'd2;

   // Angle arithmetic: 1/64 degree units, one full turn is 360 degrees.
   localparam int AZ_BITS   = 16;
   localparam int FULL_TURN = 23040;
   localparam int DIST_BITS = 18;

   // Gain division: right gain = (offset * 2^16 + span) / (2 * span).
   localparam int QUO_BITS = 15;
   localparam int NUM_BITS = 32;
   localparam int DEN_BITS = 17;

   // Q1.15 gains, carried as 17-bit values so that they multiply as signed.
   localparam int GAIN_BITS = 17;
   localparam int FRAC_BITS = 15;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE   = 17'd32768;
   localparam int                   ROUND_HALF = 16384;

   localparam int SAMPLE_FIELD_BITS = 24;

   typedef struct packed {
      logic signed [AZ_BITS-1:0]           azimuth;
      logic signed [SAMPLE_FIELD_BITS-1:0] sample;
      logic                                block_end;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]                first_channel;
      logic signed [SAMPLE_FIELD_BITS-1:0] first_sample;
      logic [CHAN_BITS-1:0]                second_channel;
      logic signed [SAMPLE_FIELD_BITS-1:0] second_sample;
      logic                                second_valid;
      logic                                block_end_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]    speaker_count;
      logic [CSR_DATA_BITS-1:0] angles_first_four;
      logic [CSR_DATA_BITS-1:0] angles_last_four;
      logic [MAP_BITS-1:0]      output_channel_map;
   } cfg_type;

   // Work item between the locate front end, the divider and the scaler.
   typedef struct packed {
      logic [NUM_BITS-1:0]          num;
      logic [DEN_BITS-1:0]          den;
      logic [QUO_BITS-1:0]          quo;
      logic                         gain_zero;
      logic                         gain_full;
      logic [CHAN_BITS-1:0]         first_channel;
      logic [CHAN_BITS-1:0]         second_channel;
      logic                         second_valid;
      logic [SAMPLE_FIELD_BITS-1:0] sample;
      logic                         block_end;
   } pan_work_type;

endpackage

FILE: hdl/rslp_locate.sv
module rslp_locate import rslp_pkg::*; #(
   parameter int MAX_SPEAKERS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   output logic            in_stall,
   input  req_payload_type in_data,
   output logic            out_valid,
   input  logic            out_stall,
   output pan_work_type    out_data
);

   localparam int STAGES   = 4;
   localparam int IDX_BITS = $clog2(MAX_SPEAKERS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_SPEAKERS);
   localparam logic signed [AZ_BITS:0]     TURN_AZ     = (AZ_BITS+1)'(FULL_TURN);
   localparam logic signed [AZ_BITS:0]     TWO_TURN_AZ = (AZ_BITS+1)'(2 * FULL_TURN);
   localparam logic signed [DIST_BITS-1:0] TURN_DIST   = DIST_BITS'(FULL_TURN);

   // Slot angles and channels unpacked from the configuration words.
   logic [ANGLE_BITS-1:0] angle [MAX_SPEAKERS];
   logic [CHAN_BITS-1:0]  chan  [MAX_SPEAKERS];

   for (genvar k = 0; k < MAX_SPEAKERS; k++) begin : g_slot
      if (k < SLOTS_PER_WORD) begin : g_lo
         assign angle[k] = cfg.angles_first_four[ANGLE_BITS*k +: ANGLE_BITS];
      end else begin : g_hi
         assign angle[k] =
            cfg.angles_last_four[ANGLE_BITS*(k-SLOTS_PER_WORD) +: ANGLE_BITS];
      end
      assign chan[k] = cfg.output_channel_map[CHAN_BITS*k +: CHAN_BITS];
   end

   // Speaker count as used: zero acts as one, large values clamp.
   logic [COUNT_BITS-1:0] count_eff;
   logic [IDX_BITS-1:0]   last_idx;
   logic                  single;

   always_comb begin
      if (cfg.speaker_count == '0) begin
         count_eff = COUNT_BITS'(1);
      end else if (cfg.speaker_count > COUNT_MAX) begin
         count_eff = COUNT_MAX;
      end else begin
         count_eff = cfg.speaker_count;
      end
   end

   assign last_idx = IDX_BITS'(count_eff - COUNT_BITS'(1));
   assign single   = (count_eff == COUNT_BITS'(1));

   // Stage advance: a stage moves when there is a bubble at or after it, or when the output is not stalled.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] en;

   for (genvar j = 0; j < STAGES; j++) begin : g_en
      assign en[j] = !out_stall || !(&valid_ff[STAGES-1:j]);
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         for (int j = 1; j < STAGES; j++) begin
            if (en[j]) valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   // Stage 1: reduce the azimuth into one turn.
   logic signed [AZ_BITS:0] az_wide;
   logic signed [AZ_BITS:0] az_mod;
   logic [ANGLE_BITS-1:0]   s1_az_ff;
   logic [SAMPLE_FIELD_BITS-1:0] s1_sample_ff;
   logic                    s1_end_ff;

   always_comb begin
      az_wide = {in_data.azimuth[AZ_BITS-1], in_data.azimuth};
      priority if (az_wide >= TURN_AZ) begin
         az_mod = az_wide - TURN_AZ;
      end else if (az_wide >= 0) begin
         az_mod = az_wide;
      end else if (az_wide >= -TURN_AZ) begin
         az_mod = az_wide + TURN_AZ;
      end else begin
         az_mod = az_wide + TWO_TURN_AZ;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_az_ff     <= az_mod[ANGLE_BITS-1:0];
         s1_sample_ff <= in_data.sample;
         s1_end_ff    <= in_data.block_end;
      end
   end

   // Stage 2: compare the azimuth against every slot angle.
   logic [MAX_SPEAKERS-1:0] hit;
   logic [MAX_SPEAKERS-1:0] s2_hit_ff;
   logic [ANGLE_BITS-1:0]   s2_az_ff;
   logic                    s2_wrap_ff;
   logic                    s2_ge_last_ff;
   logic [SAMPLE_FIELD_BITS-1:0] s2_sample_ff;
   logic                    s2_end_ff;
   logic                    ge_last;

   assign ge_last = (s1_az_ff >= angle[last_idx]);
   assign hit[0]  = 1'b0;

   // The last slot in use counts as a hit unless it is slot 0, so the search ends there.
   for (genvar k = 1; k < MAX_SPEAKERS; k++) begin : g_hit
      assign hit[k] = (angle[k] > s1_az_ff) || (IDX_BITS'(k) == last_idx);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_hit_ff     <= hit;
         s2_az_ff      <= s1_az_ff;
         s2_wrap_ff    <= ge_last || (s1_az_ff < angle[0]);
         s2_ge_last_ff <= ge_last;
         s2_sample_ff  <= s1_sample_ff;
         s2_end_ff     <= s1_end_ff;
      end
   end

   // Stage 3: pick the speaker pair and form offset and span.
   logic [IDX_BITS-1:0]        right_scan;
   logic [IDX_BITS-1:0]        left_idx;
   logic [IDX_BITS-1:0]        right_idx;
   logic signed [DIST_BITS-1:0] az_d;
   logic signed [DIST_BITS-1:0] left_d;
   logic signed [DIST_BITS-1:0] right_d;
   logic signed [DIST_BITS-1:0] offset;
   logic signed [DIST_BITS-1:0] span;
   logic signed [DIST_BITS-1:0] s3_offset_ff;
   logic signed [DIST_BITS-1:0] s3_span_ff;
   logic                        s3_single_ff;
   logic [CHAN_BITS-1:0]        s3_first_chan_ff;
   logic [CHAN_BITS-1:0]        s3_second_chan_ff;
   logic [SAMPLE_FIELD_BITS-1:0] s3_sample_ff;
   logic                        s3_end_ff;

   always_comb begin
      right_scan = last_idx;
      for (int i = MAX_SPEAKERS - 1; i >= 1; i--) begin
         if (s2_hit_ff[i]) right_scan = IDX_BITS'(i);
      end
      if (s2_wrap_ff) begin
         left_idx  = last_idx;
         right_idx = '0;
      end else begin
         left_idx  = right_scan - IDX_BITS'(1);
         right_idx = right_scan;
      end
      az_d    = DIST_BITS'(s2_az_ff);
      left_d  = DIST_BITS'(angle[left_idx]);
      right_d = DIST_BITS'(angle[right_idx]);
      if (s2_wrap_ff) begin
         span = right_d + TURN_DIST - left_d;
         if (s2_ge_last_ff) begin
            offset = az_d - left_d;
         end else begin
            offset = az_d + TURN_DIST - left_d;
         end
      end else begin
         span   = right_d - left_d;
         offset = az_d - left_d;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_offset_ff      <= offset;
         s3_span_ff        <= span;
         s3_single_ff      <= single;
         s3_first_chan_ff  <= single ? chan[0] : chan[left_idx];
         s3_second_chan_ff <= single ? '0 : chan[right_idx];
         s3_sample_ff      <= s2_sample_ff;
         s3_end_ff         <= s2_end_ff;
      end
   end

   // Stage 4: settle the saturated gain cases and set up the division.
   logic         gain_zero;
   logic         gain_full;
   pan_work_type work_in;
   pan_work_type work_ff;

   always_comb begin
      gain_zero = s3_single_ff || (s3_span_ff <= 0) || (s3_offset_ff <= 0);
      gain_full = !gain_zero && (s3_offset_ff >= s3_span_ff);
      work_in.quo            = '0;
      work_in.gain_zero      = gain_zero;
      work_in.gain_full      = gain_full;
      work_in.first_channel  = s3_first_chan_ff;
      work_in.second_channel = s3_second_chan_ff;
      work_in.second_valid   = !s3_single_ff;
      work_in.sample         = s3_sample_ff;
      work_in.block_end      = s3_end_ff;
      work_in.den            = {s3_span_ff[DEN_BITS-2:0], 1'b0};
      if (gain_zero || gain_full) begin
         work_in.num = '0;
      end else begin
         work_in.num = {s3_offset_ff[DEN_BITS-2:0], {(NUM_BITS-DEN_BITS+1){1'b0}}}
                     + NUM_BITS'(s3_span_ff[DEN_BITS-2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) work_ff <= work_in;
   end

   assign out_data = work_ff;

endmodule

FILE: hdl/rslp_divider.sv
`include "assert_macros.svh"

module rslp_divider import rslp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  pan_work_type in_data,
   output logic         out_valid,
   input  logic         out_stall,
   output pan_work_type out_data
);

   // One restoring division step per stage, most significant quotient bit first.
   localparam int STAGES = QUO_BITS;

   pan_work_type      work_ff [STAGES];
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] en;

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam int BIT = STAGES - 1 - j;

      pan_work_type        stage_in;
      pan_work_type        stage_out;
      logic                stage_valid;
      logic [NUM_BITS-1:0] trial;

      if (j == 0) begin : g_head
         assign stage_in    = in_data;
         assign stage_valid = in_valid;
      end else begin : g_body
         assign stage_in    = work_ff[j-1];
         assign stage_valid = valid_ff[j-1];
      end

      // A stage moves when there is a bubble at or after it, or when the output is not stalled.
      assign en[j] = !out_stall || !(&valid_ff[STAGES-1:j]);
      assign trial = NUM_BITS'(stage_in.den) << BIT;

      // Subtract the shifted divisor where it fits and record the bit.
      always_comb begin
         stage_out = stage_in;
         if (stage_in.num >= trial) begin
            stage_out.num      = stage_in.num - trial;
            stage_out.quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en[j]) begin
            valid_ff[j] <= stage_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) work_ff[j] <= stage_out;
      end
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = work_ff[STAGES-1];

   `ASSERT_ALWAYS(a_div_enter, in_valid && !in_stall |=> valid_ff[0],
      "accepted transfer did not enter the divider")
   `ASSERT_NEVER(a_div_den_zero,
      valid_ff[0] && !work_ff[0].gain_zero && !work_ff[0].gain_full && work_ff[0].den == '0,
      "divider started with a zero divisor")
   `ASSERT_ALWAYS(a_div_rem,
      out_valid && !out_data.gain_zero && !out_data.gain_full |-> out_data.num < NUM_BITS'(out_data.den),
      "final remainder not below the divisor")

endmodule

FILE: hdl/rslp_scale.sv
module rslp_scale import rslp_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_stall,
   input  pan_work_type    in_data,
   output logic            out_valid,
   input  logic            out_stall,
   output rsp_payload_type out_data
);

   localparam int STAGES    = 3;
   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
   localparam int Q_BITS    = PROD_BITS - FRAC_BITS;
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [PROD_BITS-1:0]   HALF    = PROD_BITS'(ROUND_HALF);

   // Stage advance: a stage moves when there is a bubble at or after it, or when the output is not stalled.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] en;

   for (genvar j = 0; j < STAGES; j++) begin : g_en
      assign en[j] = !out_stall || !(&valid_ff[STAGES-1:j]);
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         for (int j = 1; j < STAGES; j++) begin
            if (en[j]) valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   // Stage 1: pick the gains and bring the sample to its working width.
   logic [SAMPLE_BITS+SAMPLE_FIELD_BITS-1:0] sample_pad;
   logic [GAIN_BITS-1:0]          gain_right;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [GAIN_BITS-1:0]          s1_gain_l_ff;
   logic [GAIN_BITS-1:0]          s1_gain_r_ff;
   logic [CHAN_BITS-1:0]          s1_first_chan_ff;
   logic [CHAN_BITS-1:0]          s1_second_chan_ff;
   logic                          s1_second_valid_ff;
   logic                          s1_end_ff;

   assign sample_pad = {{SAMPLE_BITS{1'b0}}, in_data.sample};

   always_comb begin
      priority if (in_data.gain_zero) begin
         gain_right = '0;
      end else if (in_data.gain_full) begin
         gain_right = GAIN_ONE;
      end else begin
         gain_right = GAIN_BITS'(in_data.quo);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_sample_ff       <= signed'(sample_pad[SAMPLE_BITS-1:0]);
         s1_gain_l_ff       <= GAIN_ONE - gain_right;
         s1_gain_r_ff       <= gain_right;
         s1_first_chan_ff   <= in_data.first_channel;
         s1_second_chan_ff  <= in_data.second_channel;
         s1_second_valid_ff <= in_data.second_valid;
         s1_end_ff          <= in_data.block_end;
      end
   end

   // Stage 2: both gain products.
   logic signed [PROD_BITS-1:0] prod_l;
   logic signed [PROD_BITS-1:0] prod_r;
   logic signed [PROD_BITS-1:0] s2_prod_l_ff;
   logic signed [PROD_BITS-1:0] s2_prod_r_ff;
   logic [CHAN_BITS-1:0]        s2_first_chan_ff;
   logic [CHAN_BITS-1:0]        s2_second_chan_ff;
   logic                        s2_second_valid_ff;
   logic                        s2_end_ff;

   assign prod_l = s1_sample_ff * signed'(s1_gain_l_ff);
   assign prod_r = s1_sample_ff * signed'(s1_gain_r_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_prod_l_ff       <= prod_l;
         s2_prod_r_ff       <= prod_r;
         s2_first_chan_ff   <= s1_first_chan_ff;
         s2_second_chan_ff  <= s1_second_chan_ff;
         s2_second_valid_ff <= s1_second_valid_ff;
         s2_end_ff          <= s1_end_ff;
      end
   end

   // Stage 3: round to nearest (floor after adding one half), then saturate.
   logic signed [PROD_BITS-1:0]   round_l;
   logic signed [PROD_BITS-1:0]   round_r;
   logic signed [SAMPLE_BITS-1:0] sat_l;
   logic signed [SAMPLE_BITS-1:0] sat_r;
   logic [SAMPLE_BITS+SAMPLE_FIELD_BITS-1:0] out_pad_l;
   logic [SAMPLE_BITS+SAMPLE_FIELD_BITS-1:0] out_pad_r;
   rsp_payload_type out_in;
   rsp_payload_type out_ff;

   function automatic logic signed [SAMPLE_BITS-1:0] saturate(
      input logic signed [PROD_BITS-1:0] x
   );
      logic [Q_BITS-1:0] q;
      logic [2:0]        top;
      q   = x[PROD_BITS-1:FRAC_BITS];
      top = q[Q_BITS-1:SAMPLE_BITS-1];
      if (top == 3'b000 || top == 3'b111) begin
         return signed'(q[SAMPLE_BITS-1:0]);
      end else if (q[Q_BITS-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   always_comb begin
      round_l   = s2_prod_l_ff + HALF;
      round_r   = s2_prod_r_ff + HALF;
      sat_l     = saturate(round_l);
      sat_r     = saturate(round_r);
      out_pad_l = {{SAMPLE_FIELD_BITS{1'b0}}, sat_l};
      out_pad_r = {{SAMPLE_FIELD_BITS{1'b0}}, sat_r};
      out_in.first_channel  = s2_first_chan_ff;
      out_in.first_sample   = signed'(out_pad_l[SAMPLE_FIELD_BITS-1:0]);
      out_in.second_channel = s2_second_chan_ff;
      out_in.second_sample  = signed'(out_pad_r[SAMPLE_FIELD_BITS-1:0]);
      out_in.second_valid   = s2_second_valid_ff;
      out_in.block_end_out  = s2_end_ff;
   end

   always_ff @(posedge clock) begin
      if (en[2]) out_ff <= out_in;
   end

   assign out_data = out_ff;

endmodule

FILE: hdl/ring_speaker_linear_pan.sv
// Pipeline: 4 locate stages, 15 divider stages at one quotient bit each and 3 scale
// stages lie between an accepted request and its response.
// Throughput: one transfer per cycle; a stalled response holds the pipeline
// only once every stage is full.
// Reset clears all valid bits and sets the speaker count to 2, all angles and
// the channel map to 0.
`include "assert_macros.svh"

module ring_speaker_linear_pan import rslp_pkg::*; #(
   parameter int MAX_SPEAKERS = 8,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SPEAKER_COUNT: cfg_in.speaker_count      = csr_wdata[COUNT_BITS-1:0];
            CSR_ANGLES_LO:     cfg_in.angles_first_four  = csr_wdata;
            CSR_ANGLES_HI:     cfg_in.angles_last_four   = csr_wdata;
            CSR_CHANNEL_MAP:   cfg_in.output_channel_map = csr_wdata[MAP_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{speaker_count: COUNT_RESET, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline: speaker pair search, gain division, gain products.
   logic         loc_valid;
   logic         loc_stall;
   pan_work_type loc_work;
   logic         div_valid;
   logic         div_stall;
   pan_work_type div_work;

   rslp_locate #(
      .MAX_SPEAKERS (MAX_SPEAKERS)
   ) u_locate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_payload),
      .out_valid (loc_valid),
      .out_stall (loc_stall),
      .out_data  (loc_work)
   );

   rslp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (loc_valid),
      .in_stall  (loc_stall),
      .in_data   (loc_work),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_data  (div_work)
   );

   rslp_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_stall  (div_stall),
      .in_data   (div_work),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

   `ASSERT_ALWAYS(a_single_quiet,
      rsp_valid && !rsp_payload.second_valid |-> rsp_payload.second_sample == '0 && rsp_payload.second_channel == '0,
      "single speaker transfer drives the second speaker")
   `ASSERT_ALWAYS(a_stall_only_full, req_stall |-> rsp_valid && rsp_stall,
      "request stalled while the response side can move")
   `ASSERT_ALWAYS(a_count_reset, $past(reset) |-> cfg_ff.speaker_count == COUNT_RESET,
      "speaker count not at its reset value after reset")

endmodule

FILE: tb/ring_speaker_linear_pan_test.sv
module ring_speaker_linear_pan_test;
   import rslp_pkg::*;

   localparam int     IDLE_LIMIT  = 2000;
   localparam int     LONG_HOLD   = 150;
   localparam int     TAIL_CYCLES = 40;
   localparam int     SPEAKER_MAX = 8;
   localparam int     PHASES      = 13;
   localparam int     PHASE_ITEMS = 75;
   localparam longint UNITY_GAIN  = 32768;
   localparam longint SAMPLE_HI   = (longint'(1) <<< (SAMPLE_FIELD_BITS - 1)) - 1;
   localparam longint SAMPLE_LO   = -SAMPLE_HI - 1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_SPEAKER_COUNT;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Shadow copy of the configuration registers.
   cfg_type         pan_cfg;
   req_payload_type samples_to_send[$];
   rsp_payload_type pan_results_due[$];
   int              samples_queued = 0;
   int              samples_taken = 0;
   int              mismatch_count = 0;
   logic            req_taken = 1'b0;
   bit              idle_on = 1'b1;
   bit              hold_wanted = 1'b0;
   bit              hold_done = 1'b0;
   int              gap_left = 0;
   int              stall_left = 0;

   ring_speaker_linear_pan u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Angle and channel of one speaker slot in the shadow configuration.
   function automatic longint angle_of(int k);
      logic [ANGLE_BITS-1:0] a;
      if (k < SLOTS_PER_WORD) begin
         a = pan_cfg.angles_first_four[ANGLE_BITS*k +: ANGLE_BITS];
      end else begin
         a = pan_cfg.angles_last_four[ANGLE_BITS*(k-SLOTS_PER_WORD) +: ANGLE_BITS];
      end
      return longint'(a);
   endfunction

   function automatic logic [CHAN_BITS-1:0] channel_of(int k);
      return pan_cfg.output_channel_map[CHAN_BITS*k +: CHAN_BITS];
   endfunction

   // Sample times a Q1.15 gain, rounded half up and saturated to the sample width.
   function automatic logic signed [SAMPLE_FIELD_BITS-1:0] scale_q15(longint s, longint g);
      longint x;
      x = (s * g + ROUND_HALF) >>> FRAC_BITS;
      if (x > SAMPLE_HI) x = SAMPLE_HI;
      else if (x < SAMPLE_LO) x = SAMPLE_LO;
      return x[SAMPLE_FIELD_BITS-1:0];
   endfunction

   // Expected pan of one sample under the current shadow configuration.
   function automatic rsp_payload_type pan_sample(req_payload_type item);
      int              az;
      int              n;
      int              left_slot;
      int              right_slot;
      longint          s;
      longint          first_angle;
      longint          last_angle;
      longint          offset;
      longint          span;
      longint          g;
      rsp_payload_type r;
      az = int'(item.azimuth) % FULL_TURN;
      if (az < 0) az += FULL_TURN;
      s = longint'(item.sample);
      n = int'(pan_cfg.speaker_count);
      if (n == 0) n = 1;
      else if (n > SPEAKER_MAX) n = SPEAKER_MAX;
      r = '0;
      r.block_end_out = item.block_end;
      // A lone speaker takes the sample as it is.
      if (n == 1) begin
         r.first_channel = channel_of(0);
         r.first_sample  = item.sample;
         return r;
      end
      first_angle = angle_of(0);
      last_angle  = angle_of(n - 1);
      if (az >= last_angle || az < first_angle) begin
         // Wrap pair: the last speaker on the left, the first on the right.
         left_slot  = n - 1;
         right_slot = 0;
         span       = first_angle + FULL_TURN - last_angle;
         offset     = (az >= last_angle) ? az - last_angle : az + FULL_TURN - last_angle;
      end else begin
         // The right speaker is the lowest slot whose angle lies above the azimuth.
         right_slot = n - 1;
         for (int i = n - 1; i >= 1; i--) begin
            if (angle_of(i) > az) right_slot = i;
         end
         left_slot = right_slot - 1;
         span      = angle_of(right_slot) - angle_of(left_slot);
         offset    = az - angle_of(left_slot);
      end
      if (span <= 0 || offset <= 0) g = 0;
      else if (offset >= span) g = UNITY_GAIN;
      else g = (offset * 65536 + span) / (2 * span);
      r.first_channel  = channel_of(left_slot);
      r.first_sample   = scale_q15(s, UNITY_GAIN - g);
      r.second_channel = channel_of(right_slot);
      r.second_sample  = scale_q15(s, g);
      r.second_valid   = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
      end
   endtask

   task automatic check_result(rsp_payload_type got);
      rsp_payload_type want;
      if (pan_results_due.size() == 0) begin
         report_mismatch("transfer with no result due", 1, 0);
         return;
      end
      want = pan_results_due.pop_front();
      if (got.first_channel !== want.first_channel)
         report_mismatch("first_channel", longint'(got.first_channel),
                         longint'(want.first_channel));
      if (got.first_sample !== want.first_sample)
         report_mismatch("first_sample", longint'(got.first_sample),
                         longint'(want.first_sample));
      if (got.second_channel !== want.second_channel)
         report_mismatch("second_channel", longint'(got.second_channel),
                         longint'(want.second_channel));
      if (got.second_sample !== want.second_sample)
         report_mismatch("second_sample", longint'(got.second_sample),
                         longint'(want.second_sample));
      if (got.second_valid !== want.second_valid)
         report_mismatch("second_valid", longint'(got.second_valid),
                         longint'(want.second_valid));
      if (got.block_end_out !== want.block_end_out)
         report_mismatch("block_end_out", longint'(got.block_end_out),
                         longint'(want.block_end_out));
   endtask

   // Both channels are sampled at the rising edge; each accepted request is predicted
   // on the spot and each accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         pan_results_due.push_back(pan_sample(req_payload));
         samples_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         check_result(rsp_payload);
      end
   end

   // Request driver: a new transfer is offered only once the previous one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 11);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (samples_to_send.size() != 0) begin
            req_payload <= samples_to_send.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: random stall bursts, plus one long hold that fills the pipeline.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_wanted && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // The run is abandoned when no transfer happens on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("** ring_speaker_linear_pan: FAILED **");
      $finish;
   end

   function automatic logic [CSR_DATA_BITS-1:0] random_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[CSR_DATA_BITS-1:0];
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pack_angles(int a0, int a1, int a2, int a3);
      return {a3[ANGLE_BITS-1:0], a2[ANGLE_BITS-1:0], a1[ANGLE_BITS-1:0], a0[ANGLE_BITS-1:0]};
   endfunction

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_SPEAKER_COUNT: pan_cfg.speaker_count = data[COUNT_BITS-1:0];
         CSR_ANGLES_LO:     pan_cfg.angles_first_four = data;
         CSR_ANGLES_HI:     pan_cfg.angles_last_four = data;
         CSR_CHANNEL_MAP:   pan_cfg.output_channel_map = data[MAP_BITS-1:0];
         default: ;
      endcase
   endtask

   // Writes all four registers; the unused upper bits of the narrow ones carry noise.
   task automatic apply_setting(int count, logic [CSR_DATA_BITS-1:0] lo,
                                logic [CSR_DATA_BITS-1:0] hi, logic [MAP_BITS-1:0] map);
      logic [CSR_DATA_BITS-1:0] word;
      word = random_word();
      word[COUNT_BITS-1:0] = count[COUNT_BITS-1:0];
      write_reg(CSR_SPEAKER_COUNT, word);
      write_reg(CSR_ANGLES_LO, lo);
      write_reg(CSR_ANGLES_HI, hi);
      word = random_word();
      word[MAP_BITS-1:0] = map;
      write_reg(CSR_CHANNEL_MAP, word);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_setting();
      int                       count;
      int                       style;
      int                       a;
      logic [CSR_DATA_BITS-1:0] lo;
      logic [CSR_DATA_BITS-1:0] hi;
      style = $urandom_range(0, 9);
      if (style < 7) count = $urandom_range(2, SPEAKER_MAX);
      else if (style == 7) count = 1;
      else count = $urandom_range(0, 15);
      style = $urandom_range(0, 4);
      lo = random_word();
      hi = random_word();
      if (style < 3) begin
         // Ascending angles, with the odd pair of equal neighbors.
         a = $urandom_range(0, 2000);
         for (int k = 0; k < 2 * SLOTS_PER_WORD; k++) begin
            if (k < SLOTS_PER_WORD) lo[ANGLE_BITS*k +: ANGLE_BITS] = a[ANGLE_BITS-1:0];
            else hi[ANGLE_BITS*(k-SLOTS_PER_WORD) +: ANGLE_BITS] = a[ANGLE_BITS-1:0];
            a += $urandom_range(0, 2880);
         end
      end else if (style == 4) begin
         lo = $urandom_range(0, 1) ? '1 : '0;
         hi = $urandom_range(0, 1) ? '1 : '0;
      end
      apply_setting(count, lo, hi, MAP_BITS'($urandom));
   endtask

   task automatic queue_item(int az, int s, bit be);
      req_payload_type item;
      item.azimuth   = az[AZ_BITS-1:0];
      item.sample    = s[SAMPLE_FIELD_BITS-1:0];
      item.block_end = be;
      samples_to_send.push_back(item);
      samples_queued++;
   endtask

   task automatic queue_random_item();
      int az;
      int s;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) az = $urandom_range(0, 65535);
      else if (pick < 8) az = $urandom_range(0, FULL_TURN - 1);
      else az = int'(angle_of($urandom_range(0, SPEAKER_MAX - 1))) + $urandom_range(0, 4) - 2;
      pick = $urandom_range(0, 15);
      if (pick == 0) s = int'(SAMPLE_HI);
      else if (pick == 1) s = int'(SAMPLE_LO);
      else if (pick == 2) s = -1;
      else s = $urandom;
      queue_item(az, s, 1'($urandom_range(0, 1)));
   endtask

   // Waits until every queued sample has been taken and every result has come back.
   task automatic drain();
      while (samples_taken != samples_queued || pan_results_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      pan_cfg = '0;
      pan_cfg.speaker_count = COUNT_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset setting: two speakers both at zero, so every azimuth pans over a full turn.
      queue_item(-32768, -8388608, 1'b1);
      queue_item(32767, 8388607, 1'b0);
      queue_item(0, 12345, 1'b0);
      queue_item(-1, -1, 1'b1);
      queue_item(FULL_TURN, 8388607, 1'b0);
      queue_item(-FULL_TURN, -8388608, 1'b0);
      queue_item(FULL_TURN - 1, 8388607, 1'b1);
      queue_item(FULL_TURN / 2, -8388608, 1'b0);
      drain();

      // A single speaker, then a count of zero that behaves as one.
      apply_setting(1, random_word(), random_word(), MAP_BITS'($urandom));
      queue_item(5000, -8388608, 1'b1);
      queue_item(-7, 8388607, 1'b0);
      drain();
      apply_setting(0, random_word(), random_word(), MAP_BITS'($urandom));
      queue_item(12000, 4242, 1'b0);
      drain();

      // Eight evenly spread speakers: on a speaker, between, on and past the last,
      // below the first and on the first.
      apply_setting(8, pack_angles(1000, 3800, 6600, 9400),
                    pack_angles(12200, 15000, 17800, 20600), 24'o01234567);
      queue_item(9400, 8388607, 1'b0);
      queue_item(5000, -8388608, 1'b1);
      queue_item(20600, 777777, 1'b0);
      queue_item(22000, -8388608, 1'b0);
      queue_item(500, 8388607, 1'b1);
      queue_item(1000, -3, 1'b0);
      drain();

      // Count above the maximum, with every angle beyond a full turn.
      apply_setting(15, '1, '1, '1);
      queue_item(100, 8388607, 1'b0);
      queue_item(-32768, -8388608, 1'b1);
      drain();

      // Wrap span of zero: the whole gain goes to the left speaker.
      apply_setting(2, pack_angles(10, 23050, 0, 0), '0, MAP_BITS'($urandom));
      queue_item(5, 8388607, 1'b0);
      drain();

      // Unsorted angles are taken as given.
      apply_setting(4, pack_angles(9000, 3000, 15000, 6000), '0, MAP_BITS'($urandom));
      queue_item(4000, -8388608, 1'b1);
      queue_item(12000, 8388607, 1'b0);
      drain();

      // Random settings with random samples; no idling in the closing phases.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         idle_on = (p < PHASES - 3) && ($urandom_range(0, 3) != 0);
         random_setting();
         if (p == 5) begin
            // The sender pauses mid-phase until every result is back.
            repeat (PHASE_ITEMS / 2) queue_random_item();
            drain();
            repeat (PHASE_ITEMS - PHASE_ITEMS / 2) queue_random_item();
         end else begin
            repeat (PHASE_ITEMS) queue_random_item();
         end
         if (p == 3) hold_wanted = 1'b1;
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** ring_speaker_linear_pan: PASSED **");
      end else begin
         $display("** ring_speaker_linear_pan: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/rslp_pkg.sv
hdl/rslp_locate.sv
hdl/rslp_divider.sv
hdl/rslp_scale.sv
hdl/ring_speaker_linear_pan.sv
tb/ring_speaker_linear_pan_test.sv
